### design/hcp_pkg.sv
// ----------------------------------------------------------------------------
// hcp_pkg: shared types and constants for the hypergraph core peeling block
// Store sizes, word formats, controller states and datapath status flags.
// ----------------------------------------------------------------------------
package hcp_pkg;

	localparam int MAX_NODES = 1024;
	localparam int MAX_EDGES = 1024;
	localparam int MAX_PINS  = 4096;

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int EDGE_W = $clog2(MAX_EDGES);
	localparam int PIN_W  = $clog2(MAX_PINS);
	localparam int PCNT_W = PIN_W + 1;
	localparam int ECNT_W = EDGE_W + 1;
	localparam int DEG_W  = 11;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_PEEL  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2,
		ST_PHASE  = 2'd3
	} sts_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [NODE_W-1:0] node;
		logic              edge_end;
	} in_word_t;

	typedef struct packed {
		sts_t             status;
		logic [DEG_W-1:0] core;
		logic             node_present;
	} out_word_t;

	// per-node entry: current degree, presence, peeled mark
	typedef struct packed {
		logic [DEG_W-1:0] deg;
		logic             pres;
		logic             peeled;
	} node_ent_t;

	typedef enum logic [4:0] {
		S_SWEEP_RST,
		S_IDLE,
		S_DECODE,
		S_DUP_RD,
		S_DUP_CMP,
		S_ADD_WR,
		S_CLOSE,
		S_CL_RD,
		S_CL_NODE,
		S_CL_WR,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_PICK,
		S_E_RD0,
		S_E_RD1,
		S_E_RD2,
		S_H_RD,
		S_H_CMP,
		S_H_DONE,
		S_D_RD,
		S_D_NODE,
		S_D_WR,
		S_Q_RD,
		S_Q_CHK,
		S_SWEEP_CLR,
		S_RESP
	} fsm_t;

	typedef struct packed {
		cmd_t cmd;
		logic peel_done;
		logic pins_full;
		logic last;
		logic ptr_end;
		logic idx_end;
		logic edge_end;
		logic hit;
		logic found;
		logic rem;
		logic close_ok;
		logic pres;
		logic out_free;
	} dp_stat_t;

endpackage

### design/hcp_req_if.sv
// ----------------------------------------------------------------------------
// hcp_req_if: command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface hcp_req_if;
	logic               valid;
	logic               ready;
	hcp_pkg::in_word_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### design/hcp_rsp_if.sv
// ----------------------------------------------------------------------------
// hcp_rsp_if: response channel
// Valid/ready channel carrying one response word.
// ----------------------------------------------------------------------------
interface hcp_rsp_if;
	logic               valid;
	logic               ready;
	hcp_pkg::out_word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### design/hcp_ctrl.sv
// ----------------------------------------------------------------------------
// hcp_ctrl: sequencer for load, peel, query and clear
// Walks the datapath through scans of pins, nodes and edges.
// ----------------------------------------------------------------------------
module hcp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              word_valid,
	input  hcp_pkg::dp_stat_t stat,
	output hcp_pkg::fsm_t     op,
	output logic              word_ready
);

	hcp_pkg::fsm_t state_q;
	hcp_pkg::fsm_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcp_pkg::S_SWEEP_RST;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			hcp_pkg::S_SWEEP_RST: if (stat.idx_end) state_nxt = hcp_pkg::S_IDLE;
			hcp_pkg::S_IDLE:      if (word_valid) state_nxt = hcp_pkg::S_DECODE;
			hcp_pkg::S_DECODE: begin
				case (stat.cmd)
					hcp_pkg::CMD_ADD: begin
						if (stat.peel_done)
							state_nxt = hcp_pkg::S_RESP;
						else if (stat.pins_full)
							state_nxt = stat.last ? hcp_pkg::S_CLOSE : hcp_pkg::S_RESP;
						else
							state_nxt = hcp_pkg::S_DUP_RD;
					end
					hcp_pkg::CMD_PEEL:
						state_nxt = stat.peel_done ? hcp_pkg::S_RESP : hcp_pkg::S_SCAN_RD;
					hcp_pkg::CMD_QUERY:
						state_nxt = stat.peel_done ? hcp_pkg::S_Q_RD : hcp_pkg::S_RESP;
					default: state_nxt = hcp_pkg::S_SWEEP_CLR;
				endcase
			end
			hcp_pkg::S_DUP_RD:
				state_nxt = stat.ptr_end ? hcp_pkg::S_ADD_WR : hcp_pkg::S_DUP_CMP;
			hcp_pkg::S_DUP_CMP: state_nxt = hcp_pkg::S_DUP_RD;
			hcp_pkg::S_ADD_WR:
				state_nxt = stat.last ? hcp_pkg::S_CLOSE : hcp_pkg::S_RESP;
			hcp_pkg::S_CLOSE:
				state_nxt = stat.close_ok ? hcp_pkg::S_CL_RD : hcp_pkg::S_RESP;
			hcp_pkg::S_CL_RD:
				state_nxt = stat.ptr_end ? hcp_pkg::S_RESP : hcp_pkg::S_CL_NODE;
			hcp_pkg::S_CL_NODE:  state_nxt = hcp_pkg::S_CL_WR;
			hcp_pkg::S_CL_WR:    state_nxt = hcp_pkg::S_CL_RD;
			hcp_pkg::S_SCAN_RD:  state_nxt = hcp_pkg::S_SCAN_CMP;
			hcp_pkg::S_SCAN_CMP:
				state_nxt = stat.idx_end ? hcp_pkg::S_PICK : hcp_pkg::S_SCAN_RD;
			hcp_pkg::S_PICK:
				state_nxt = stat.found ? hcp_pkg::S_E_RD0 : hcp_pkg::S_RESP;
			hcp_pkg::S_E_RD0:
				state_nxt = stat.edge_end ? hcp_pkg::S_SCAN_RD : hcp_pkg::S_E_RD1;
			hcp_pkg::S_E_RD1:    state_nxt = hcp_pkg::S_E_RD2;
			hcp_pkg::S_E_RD2:
				state_nxt = stat.rem ? hcp_pkg::S_E_RD0 : hcp_pkg::S_H_RD;
			hcp_pkg::S_H_RD:
				state_nxt = stat.ptr_end ? hcp_pkg::S_H_DONE : hcp_pkg::S_H_CMP;
			hcp_pkg::S_H_CMP:    state_nxt = hcp_pkg::S_H_RD;
			hcp_pkg::S_H_DONE:
				state_nxt = stat.hit ? hcp_pkg::S_D_RD : hcp_pkg::S_E_RD0;
			hcp_pkg::S_D_RD:
				state_nxt = stat.ptr_end ? hcp_pkg::S_E_RD0 : hcp_pkg::S_D_NODE;
			hcp_pkg::S_D_NODE:   state_nxt = hcp_pkg::S_D_WR;
			hcp_pkg::S_D_WR:     state_nxt = hcp_pkg::S_D_RD;
			hcp_pkg::S_Q_RD:     state_nxt = hcp_pkg::S_Q_CHK;
			hcp_pkg::S_Q_CHK:    state_nxt = hcp_pkg::S_RESP;
			hcp_pkg::S_SWEEP_CLR: if (stat.idx_end) state_nxt = hcp_pkg::S_RESP;
			hcp_pkg::S_RESP:     if (stat.out_free) state_nxt = hcp_pkg::S_IDLE;
			default:             state_nxt = hcp_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		op         = state_q;
		word_ready = (state_q == hcp_pkg::S_IDLE);
	end

endmodule

### design/hcp_datapath.sv
// ----------------------------------------------------------------------------
// hcp_datapath: stores, counters and compare logic
// Pin, edge, node and core memories with the scan pointers and result register.
// ----------------------------------------------------------------------------
module hcp_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  hcp_pkg::fsm_t      op,
	input  logic               in_take,
	input  hcp_pkg::in_word_t  in_word,
	output hcp_pkg::dp_stat_t  stat,
	output logic               out_valid,
	output hcp_pkg::out_word_t out_word,
	input  logic               out_ready
);

	// memories
	logic [hcp_pkg::NODE_W-1:0] pin_mem  [hcp_pkg::MAX_PINS];
	logic [hcp_pkg::PIN_W-1:0]  edge_mem [hcp_pkg::MAX_EDGES];
	logic                       rem_mem  [hcp_pkg::MAX_EDGES];
	hcp_pkg::node_ent_t         node_mem [hcp_pkg::MAX_NODES];
	logic [hcp_pkg::DEG_W-1:0]  core_mem [hcp_pkg::MAX_NODES];

	// control registers
	logic [hcp_pkg::PCNT_W-1:0] pin_total_q;
	logic [hcp_pkg::PCNT_W-1:0] open_first_q;
	logic [hcp_pkg::ECNT_W-1:0] edge_total_q;
	logic [hcp_pkg::DEG_W-1:0]  rc_q;
	logic                       peel_done_q;
	logic [hcp_pkg::NODE_W-1:0] idx_q;
	logic                       out_valid_q;

	// working registers
	hcp_pkg::cmd_t              cmd_q;
	logic [hcp_pkg::NODE_W-1:0] node_q;
	logic                       last_q;
	hcp_pkg::sts_t              st_q;
	logic [hcp_pkg::DEG_W-1:0]  core_q;
	logic                       pres_q;
	logic [hcp_pkg::PCNT_W-1:0] ptr_q;
	logic [hcp_pkg::PCNT_W-1:0] stop_q;
	logic [hcp_pkg::PCNT_W-1:0] start_q;
	logic [hcp_pkg::ECNT_W-1:0] edge_q;
	logic [hcp_pkg::NODE_W-1:0] best_q;
	logic [hcp_pkg::DEG_W-1:0]  best_deg_q;
	logic                       found_q;
	logic                       hit_q;
	logic                       rem_q;
	hcp_pkg::out_word_t         out_q;

	// read data
	logic [hcp_pkg::NODE_W-1:0] pin_rd_q;
	logic [hcp_pkg::PIN_W-1:0]  edge_rd_q;
	logic                       rem_rd_q;
	hcp_pkg::node_ent_t         node_rd_q;
	logic [hcp_pkg::DEG_W-1:0]  core_rd_q;

	logic [hcp_pkg::PCNT_W-1:0] count;
	logic [hcp_pkg::PCNT_W-1:0] ptr_lim;
	logic [hcp_pkg::ECNT_W-1:0] edge_nxt;
	logic [hcp_pkg::EDGE_W-1:0] edge_raddr;
	logic [hcp_pkg::NODE_W-1:0] node_raddr;
	logic                       node_we;
	logic [hcp_pkg::NODE_W-1:0] node_waddr;
	hcp_pkg::node_ent_t         node_wdata;
	logic                       rem_we;
	logic [hcp_pkg::EDGE_W-1:0] rem_waddr;
	logic                       rem_wd;
	logic                       close_ok;
	logic                       out_free;
	logic                       better;
	logic [hcp_pkg::DEG_W-1:0]  rc_new;

	// derived values
	assign count    = pin_total_q - open_first_q;
	assign close_ok = (count >= hcp_pkg::PCNT_W'(2)) &&
		(edge_total_q < hcp_pkg::ECNT_W'(hcp_pkg::MAX_EDGES));
	assign edge_nxt = edge_q + hcp_pkg::ECNT_W'(1);
	assign ptr_lim  = (op == hcp_pkg::S_H_RD || op == hcp_pkg::S_D_RD) ? stop_q : pin_total_q;
	assign out_free = !out_valid_q || out_ready;
	assign rc_new   = (best_deg_q > rc_q) ? best_deg_q : rc_q;
	assign better   = node_rd_q.pres && !node_rd_q.peeled &&
		(!found_q || node_rd_q.deg < best_deg_q);
	assign edge_raddr = (op == hcp_pkg::S_E_RD1) ? edge_nxt[hcp_pkg::EDGE_W-1:0]
		: edge_q[hcp_pkg::EDGE_W-1:0];

	// node store address and write selection
	always_comb begin
		case (op)
			hcp_pkg::S_SCAN_RD:                    node_raddr = idx_q;
			hcp_pkg::S_CL_NODE, hcp_pkg::S_D_NODE: node_raddr = pin_rd_q;
			default:                               node_raddr = node_q;
		endcase
		node_we    = 1'b0;
		node_waddr = pin_rd_q;
		node_wdata = node_rd_q;
		case (op)
			hcp_pkg::S_SWEEP_RST, hcp_pkg::S_SWEEP_CLR: begin
				node_we    = 1'b1;
				node_waddr = idx_q;
				node_wdata = '0;
			end
			hcp_pkg::S_CL_WR: begin
				node_we         = 1'b1;
				node_wdata.deg  = node_rd_q.deg + hcp_pkg::DEG_W'(1);
				node_wdata.pres = 1'b1;
			end
			hcp_pkg::S_PICK: begin
				node_we           = found_q;
				node_waddr        = best_q;
				node_wdata.deg    = best_deg_q;
				node_wdata.pres   = 1'b1;
				node_wdata.peeled = 1'b1;
			end
			hcp_pkg::S_D_WR: begin
				node_we        = !node_rd_q.peeled && (node_rd_q.deg != '0);
				node_wdata.deg = node_rd_q.deg - hcp_pkg::DEG_W'(1);
			end
			default: node_we = 1'b0;
		endcase
	end

	// removed-mark write selection
	always_comb begin
		rem_we    = 1'b0;
		rem_waddr = edge_q[hcp_pkg::EDGE_W-1:0];
		rem_wd    = 1'b1;
		if (op == hcp_pkg::S_CLOSE && close_ok) begin
			rem_we    = 1'b1;
			rem_waddr = edge_total_q[hcp_pkg::EDGE_W-1:0];
			rem_wd    = 1'b0;
		end else if (op == hcp_pkg::S_H_DONE && hit_q) begin
			rem_we = 1'b1;
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (op == hcp_pkg::S_ADD_WR && !hit_q)
			pin_mem[pin_total_q[hcp_pkg::PIN_W-1:0]] <= node_q;
		pin_rd_q <= pin_mem[ptr_q[hcp_pkg::PIN_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (op == hcp_pkg::S_CLOSE && close_ok)
			edge_mem[edge_total_q[hcp_pkg::EDGE_W-1:0]] <= open_first_q[hcp_pkg::PIN_W-1:0];
		edge_rd_q <= edge_mem[edge_raddr];
	end

	always_ff @(posedge clk) begin
		if (rem_we)
			rem_mem[rem_waddr] <= rem_wd;
		rem_rd_q <= rem_mem[edge_raddr];
	end

	always_ff @(posedge clk) begin
		if (node_we)
			node_mem[node_waddr] <= node_wdata;
		node_rd_q <= node_mem[node_raddr];
	end

	always_ff @(posedge clk) begin
		if (op == hcp_pkg::S_PICK && found_q)
			core_mem[best_q] <= rc_new;
		core_rd_q <= core_mem[node_q];
	end

	function automatic logic [hcp_pkg::ECNT_W-1:0] edge_nxt_total(
		input logic [hcp_pkg::ECNT_W-1:0] n);
		return n + hcp_pkg::ECNT_W'(1);
	endfunction

	// counters and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_total_q  <= '0;
			open_first_q <= '0;
			edge_total_q <= '0;
			rc_q         <= '0;
			peel_done_q  <= 1'b0;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			case (op)
				hcp_pkg::S_DECODE: begin
					idx_q <= '0;
					if (cmd_q == hcp_pkg::CMD_CLEAR) begin
						pin_total_q  <= '0;
						open_first_q <= '0;
						edge_total_q <= '0;
						rc_q         <= '0;
						peel_done_q  <= 1'b0;
					end
				end
				hcp_pkg::S_ADD_WR:
					if (!hit_q) pin_total_q <= pin_total_q + hcp_pkg::PCNT_W'(1);
				hcp_pkg::S_CLOSE: begin
					if (close_ok) begin
						edge_total_q <= edge_nxt_total(edge_total_q);
						open_first_q <= pin_total_q;
					end else begin
						pin_total_q <= open_first_q;
					end
				end
				hcp_pkg::S_SCAN_CMP, hcp_pkg::S_SWEEP_RST, hcp_pkg::S_SWEEP_CLR:
					idx_q <= idx_q + hcp_pkg::NODE_W'(1);
				hcp_pkg::S_PICK: begin
					idx_q <= '0;
					if (found_q) rc_q <= rc_new;
					else         peel_done_q <= 1'b1;
				end
				default: ;
			endcase
			if (op == hcp_pkg::S_RESP && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// scan pointers, flags and result fields
	always_ff @(posedge clk) begin
		case (op)
			hcp_pkg::S_IDLE: begin
				if (in_take) begin
					cmd_q  <= in_word.cmd;
					node_q <= in_word.node;
					last_q <= in_word.edge_end;
					st_q   <= hcp_pkg::ST_OK;
					core_q <= '0;
					pres_q <= 1'b0;
				end
			end
			hcp_pkg::S_DECODE: begin
				ptr_q   <= open_first_q;
				hit_q   <= 1'b0;
				found_q <= 1'b0;
				case (cmd_q)
					hcp_pkg::CMD_ADD: begin
						if (peel_done_q)
							st_q <= hcp_pkg::ST_PHASE;
						else if (pin_total_q >= hcp_pkg::PCNT_W'(hcp_pkg::MAX_PINS))
							st_q <= hcp_pkg::ST_FULL;
					end
					hcp_pkg::CMD_PEEL: begin
						if (peel_done_q) begin
							st_q   <= hcp_pkg::ST_PHASE;
							core_q <= rc_q;
						end
					end
					hcp_pkg::CMD_QUERY:
						if (!peel_done_q) st_q <= hcp_pkg::ST_PHASE;
					default: ;
				endcase
			end
			hcp_pkg::S_DUP_CMP: begin
				if (pin_rd_q == node_q) hit_q <= 1'b1;
				ptr_q <= ptr_q + hcp_pkg::PCNT_W'(1);
			end
			hcp_pkg::S_CLOSE: begin
				if (count >= hcp_pkg::PCNT_W'(2) && !close_ok) st_q <= hcp_pkg::ST_FULL;
				ptr_q <= open_first_q;
			end
			hcp_pkg::S_CL_WR, hcp_pkg::S_D_WR:
				ptr_q <= ptr_q + hcp_pkg::PCNT_W'(1);
			hcp_pkg::S_SCAN_CMP: begin
				if (better) begin
					best_q     <= idx_q;
					best_deg_q <= node_rd_q.deg;
					found_q    <= 1'b1;
				end
			end
			hcp_pkg::S_PICK: begin
				if (!found_q) core_q <= rc_q;
				found_q <= 1'b0;
				edge_q  <= '0;
			end
			hcp_pkg::S_E_RD1: begin
				ptr_q   <= {1'b0, edge_rd_q};
				start_q <= {1'b0, edge_rd_q};
				rem_q   <= rem_rd_q;
				hit_q   <= 1'b0;
			end
			hcp_pkg::S_E_RD2: begin
				stop_q <= (edge_nxt < edge_total_q) ? {1'b0, edge_rd_q} : open_first_q;
				if (rem_q) edge_q <= edge_nxt;
			end
			hcp_pkg::S_H_CMP: begin
				if (pin_rd_q == best_q) hit_q <= 1'b1;
				ptr_q <= ptr_q + hcp_pkg::PCNT_W'(1);
			end
			hcp_pkg::S_H_DONE: begin
				if (hit_q) ptr_q  <= start_q;
				else       edge_q <= edge_nxt;
			end
			hcp_pkg::S_D_RD:
				if (ptr_q == ptr_lim) edge_q <= edge_nxt;
			hcp_pkg::S_Q_CHK: begin
				if (!node_rd_q.pres) begin
					st_q <= hcp_pkg::ST_ABSENT;
				end else begin
					core_q <= core_rd_q;
					pres_q <= 1'b1;
				end
			end
			hcp_pkg::S_RESP: begin
				if (out_free) begin
					out_q.status       <= st_q;
					out_q.core         <= core_q;
					out_q.node_present <= pres_q;
				end
			end
			default: ;
		endcase
	end

	// status to the sequencer
	always_comb begin
		stat.cmd       = cmd_q;
		stat.peel_done = peel_done_q;
		stat.pins_full = (pin_total_q >= hcp_pkg::PCNT_W'(hcp_pkg::MAX_PINS));
		stat.last      = last_q;
		stat.ptr_end   = (ptr_q == ptr_lim);
		stat.idx_end   = (idx_q == hcp_pkg::NODE_W'(hcp_pkg::MAX_NODES - 1));
		stat.edge_end  = (edge_q == edge_total_q);
		stat.hit       = hit_q;
		stat.found     = found_q;
		stat.rem       = rem_q;
		stat.close_ok  = close_ok;
		stat.pres      = node_rd_q.pres;
		stat.out_free  = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

### design/hypergraph_core_peeling.sv
// ----------------------------------------------------------------------------
// hypergraph_core_peeling: hypergraph k-core decomposition by peeling
// Loads hyperedges pin by pin, peels on command, answers core queries.
//
//   channel  dir  word                           handshake
//   req      in   cmd, node, edge_end            valid/ready
//   rsp      out  status, core, node_present     valid/ready
//
// After reset, a sweep clears the node store; req.ready is low.
// Add pin: checks the open edge for a duplicate and writes the pin if new;
// closing the edge walks its pins to raise node degrees. Query: reads the node
// and core stores. Clear: sweeps the node store. Peel: per peeled node, a scan
// of the node store, then per live edge a search of its pins for that node and,
// if found, a pass over its pins lowering degrees; removed edges are skipped.
// One word at a time; a held response does not block the next word from being taken.
// ----------------------------------------------------------------------------
module hypergraph_core_peeling (
	input  logic clk,
	input  logic arst_n,
	hcp_req_if.sink   req,
	hcp_rsp_if.source rsp
);

	hcp_pkg::fsm_t     op;
	hcp_pkg::dp_stat_t stat;
	logic              word_ready;

	hcp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (req.valid),
		.stat       (stat),
		.op         (op),
		.word_ready (word_ready)
	);

	hcp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_take   (req.valid && word_ready),
		.in_word   (req.data),
		.stat      (stat),
		.out_valid (rsp.valid),
		.out_word  (rsp.data),
		.out_ready (rsp.ready)
	);

	assign req.ready = word_ready;

`ifndef SYNTH
	// a taken word keeps the sequencer busy on the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("req.ready high right after a word was taken");

	// a new response appears only out of the response state
	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(op == hcp_pkg::S_RESP))
		else $error("response raised outside response state");
`endif

endmodule

### verif/hcp_checker.sv
// ----------------------------------------------------------------------------
// hcp_checker: response checker for the hypergraph core peeling block
// Watches both channels, keeps its own copy of the graph stores, works out
// the answer to every accepted command word and compares each response word
// field by field with the oldest answer still owed.
// ----------------------------------------------------------------------------
module hcp_checker
	import hcp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	hcp_req_if   req,
	hcp_rsp_if   rsp,
	output int   fails,
	output int   pending
);

	// shadow graph stores
	int   pin_node [MAX_PINS];
	int   edge_first [MAX_EDGES];
	bit   edge_gone [MAX_EDGES];
	int   degree [MAX_NODES];
	bit   in_graph [MAX_NODES];
	bit   peeled [MAX_NODES];
	int   core_of [MAX_NODES];
	int   pin_cnt;
	int   edge_cnt;
	int   open_first;
	int   max_core;
	bit   peeled_all;

	out_word_t owed_q [$];

	function automatic void wipe_graph();
		for (int i = 0; i < MAX_NODES; i++) begin
			degree[i]   = 0;
			in_graph[i] = 0;
			peeled[i]   = 0;
		end
		for (int i = 0; i < MAX_EDGES; i++)
			edge_gone[i] = 0;
		pin_cnt    = 0;
		edge_cnt   = 0;
		open_first = 0;
		max_core   = 0;
		peeled_all = 0;
	endfunction

	// close the open edge; returns 1 when the edge store was full
	function automatic bit close_open_edge();
		int cnt;
		cnt = pin_cnt - open_first;
		if (cnt < 2 || edge_cnt >= MAX_EDGES) begin
			pin_cnt = open_first;
			return cnt >= 2;
		end
		edge_first[edge_cnt] = open_first;
		edge_gone[edge_cnt]  = 0;
		edge_cnt++;
		for (int p = open_first; p < pin_cnt; p++) begin
			degree[pin_node[p]]++;
			in_graph[pin_node[p]] = 1;
		end
		open_first = pin_cnt;
		return 0;
	endfunction

	function automatic int edge_stop(int e);
		return (e + 1 < edge_cnt) ? edge_first[e + 1] : open_first;
	endfunction

	// min-degree peeling, lower index wins ties
	function automatic void run_peel();
		int  best;
		int  best_deg;
		bit  found;
		bit  has;
		forever begin
			found = 0;
			best = 0;
			best_deg = 0;
			for (int n = 0; n < MAX_NODES; n++)
				if (in_graph[n] && !peeled[n] && (!found || degree[n] < best_deg)) begin
					best = n;
					best_deg = degree[n];
					found = 1;
				end
			if (!found)
				break;
			if (best_deg > max_core)
				max_core = best_deg;
			core_of[best] = max_core;
			peeled[best] = 1;
			for (int e = 0; e < edge_cnt; e++) begin
				if (edge_gone[e])
					continue;
				has = 0;
				for (int p = edge_first[e]; p < edge_stop(e); p++)
					if (pin_node[p] == best)
						has = 1;
				if (!has)
					continue;
				edge_gone[e] = 1;
				for (int p = edge_first[e]; p < edge_stop(e); p++)
					if (!peeled[pin_node[p]] && degree[pin_node[p]] > 0)
						degree[pin_node[p]]--;
			end
		end
		peeled_all = 1;
	endfunction

	function automatic out_word_t answer(in_word_t w);
		out_word_t r;
		bit        dup;
		r = '0;
		r.status = ST_OK;
		case (w.cmd)
			CMD_ADD: begin
				if (peeled_all) begin
					r.status = ST_PHASE;
				end else begin
					if (pin_cnt >= MAX_PINS) begin
						r.status = ST_FULL;
					end else begin
						dup = 0;
						for (int p = open_first; p < pin_cnt; p++)
							if (pin_node[p] == int'(w.node))
								dup = 1;
						if (!dup)
							pin_node[pin_cnt++] = int'(w.node);
					end
					if (w.edge_end && close_open_edge())
						r.status = ST_FULL;
				end
			end
			CMD_PEEL: begin
				if (peeled_all)
					r.status = ST_PHASE;
				else
					run_peel();
				r.core = DEG_W'(max_core);
			end
			CMD_QUERY: begin
				if (!peeled_all) begin
					r.status = ST_PHASE;
				end else if (!in_graph[w.node]) begin
					r.status = ST_ABSENT;
				end else begin
					r.core = DEG_W'(core_of[w.node]);
					r.node_present = 1;
				end
			end
			default: wipe_graph();
		endcase
		return r;
	endfunction

	// predict on accepted commands, compare on accepted responses
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		int        bad;
		if (!arst_n) begin
			wipe_graph();
			owed_q.delete();
			fails   <= 0;
			pending <= 0;
		end else begin
			bad = 0;
			if (req.valid && req.ready)
				owed_q.insert(owed_q.size(), answer(req.data));
			if (rsp.valid && rsp.ready) begin
				if (owed_q.size() == 0) begin
					$error("response word with nothing owed: %p", rsp.data);
					bad++;
				end else begin
					want = owed_q.pop_front();
					if (rsp.data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.data.status);
						bad++;
					end
					if (rsp.data.core !== want.core) begin
						$error("core: expected %0d, got %0d", want.core, rsp.data.core);
						bad++;
					end
					if (rsp.data.node_present !== want.node_present) begin
						$error("node_present: expected %0d, got %0d", want.node_present,
							rsp.data.node_present);
						bad++;
					end
				end
			end
			fails   <= fails + bad;
			pending <= owed_q.size();
		end
	end

endmodule

### verif/hypergraph_core_peeling_test.sv
// ----------------------------------------------------------------------------
// hypergraph_core_peeling_test: testbench top for hypergraph_core_peeling
// Drives directed and random command words (small random graphs, peel,
// queries), stalls the response side at random, and gives the verdict from
// the checker's failure count.
// ----------------------------------------------------------------------------
module hypergraph_core_peeling_test;
	import hcp_pkg::*;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   words_sent;

	hcp_req_if req ();
	hcp_rsp_if rsp ();

	hypergraph_core_peeling u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	hcp_checker u_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.fails   (fails),
		.pending (pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// mostly no gap, sometimes short, rarely long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 13)
			return 0;
		if (r < 19)
			return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// offer one word and hold it until taken
	task automatic send(cmd_t c, int n, bit last, bit no_gap = 0);
		int g;
		in_word_t w;
		w.cmd = c;
		w.node = n[NODE_W-1:0];
		w.edge_end = last;
		req.valid <= 1'b1;
		req.data <= w;
		do
			@(posedge clk);
		while (!req.ready);
		words_sent++;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// stop offering and wait until every owed response has come
	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// one random graph phase: clear, load, peel, query
	task automatic graph_phase();
		int pool [16];
		int k;
		int edges;
		int sz;
		k = $urandom_range(3, 14);
		for (int i = 0; i < k; i++)
			pool[i] = $urandom_range(0, 1023);
		send(CMD_CLEAR, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0)
			send(CMD_QUERY, pool[0], 1'($urandom_range(0, 1)));
		edges = $urandom_range(2, 10);
		for (int e = 0; e < edges; e++) begin
			sz = $urandom_range(1, 5);
			for (int p = 0; p < sz; p++)
				send(CMD_ADD, pool[$urandom_range(0, k - 1)], p == sz - 1);
			if ($urandom_range(0, 7) == 0)
				send(CMD_ADD, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
		end
		// sometimes leave an edge open across the peel
		if ($urandom_range(0, 3) == 0)
			send(CMD_ADD, pool[$urandom_range(0, k - 1)], 1'b0);
		wait_drained();
		send(CMD_PEEL, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0)
			send(CMD_PEEL, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0)
			send(CMD_ADD, pool[0], 1'($urandom_range(0, 1)));
		for (int q = 0; q < k + 2; q++)
			send(CMD_QUERY, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
				: pool[$urandom_range(0, k - 1)], 1'($urandom_range(0, 1)));
	endtask

	// response side: random stalls, one long hold-off
	initial begin
		int got;
		bit held;
		int r;
		got = 0;
		held = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				got++;
			if (!held && got >= 300) begin
				held = 1;
				rsp.ready <= 1'b0;
				repeat (4000) @(posedge clk);
			end else begin
				r = $urandom_range(0, 19);
				if (r < 14) begin
					rsp.ready <= 1'b1;
				end else begin
					rsp.ready <= 1'b0;
					repeat ((r == 19) ? $urandom_range(15, 60) : $urandom_range(0, 2))
						@(posedge clk);
				end
			end
		end
	end

	// stimulus and verdict
	initial begin
		words_sent = 0;
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: phase errors, duplicates, short edges, open edge at peel
		send(CMD_QUERY, 1023, 1'b1);
		send(CMD_ADD, 0, 1'b0);
		send(CMD_ADD, 0, 1'b0);
		send(CMD_ADD, 1023, 1'b1);
		send(CMD_ADD, 512, 1'b1);
		send(CMD_ADD, 0, 1'b0);
		send(CMD_ADD, 341, 1'b0);
		send(CMD_ADD, 682, 1'b1);
		send(CMD_ADD, 1023, 1'b0);
		send(CMD_ADD, 341, 1'b1);
		send(CMD_ADD, 777, 1'b0);
		wait_drained();
		send(CMD_PEEL, 0, 1'b0);
		send(CMD_PEEL, 1023, 1'b1);
		send(CMD_QUERY, 0, 1'b0);
		send(CMD_QUERY, 1023, 1'b1);
		send(CMD_QUERY, 512, 1'b0);
		send(CMD_QUERY, 777, 1'b0);
		send(CMD_ADD, 5, 1'b1);
		send(CMD_CLEAR, 0, 1'b0);
		send(CMD_QUERY, 0, 1'b0);

		// random graphs
		while (words_sent < 500)
			graph_phase();

		wait_drained();
		repeat (100) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#40000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### files.f
design/hcp_pkg.sv
design/hcp_req_if.sv
design/hcp_rsp_if.sv
design/hcp_ctrl.sv
design/hcp_datapath.sv
design/hypergraph_core_peeling.sv
verif/hcp_checker.sv
verif/hypergraph_core_peeling_test.sv
